>>> design/tksh_pkg.sv
// Shared types, constants and helpers for the top-k smallest selector.
// No dependencies; imported by top_k_smallest_heap.
`default_nettype none

package tksh_pkg;

    localparam int DATA_W         = 64;
    localparam int KLIMIT_W       = 6;
    localparam int KLIMIT_RESET   = 63;
    localparam int HEAP_DEPTH_DEF = 64;

    // Request codes on req_type
    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef logic signed [DATA_W-1:0] data_t;

    // Strict signed less-than between two samples
    function automatic logic val_less(input data_t a, input data_t b);
        return a < b;
    endfunction

endpackage

`default_nettype wire

>>> design/top_k_smallest_heap.sv
// Top-k smallest selector built around a bounded binary max-heap in one memory.
// Depends on tksh_pkg (types, request codes, compare helper).
`default_nettype none

// Channel    | Direction | Handshake                  | Payload
// -----------+-----------+----------------------------+-----------------------------------
// request    | in        | start & !busy              | req_type, value
// result     | out       | done (one cycle, no stall) | value_res, last, empty_res
// k_limit    | in        | k_limit_we                 | k_limit (saturated at depth - 1)
//
// A push sifts the new sample up U levels, then trims the maximum (read, load, then D
// levels of sift-down), U and D each at most log2(HEAP_DEPTH); the trim part is
// skipped when the count stays within k_limit.
// A drain of n items runs n removals (read, load, sift-down), then an emit phase;
// the n results leave on done back to back.
// An empty drain gives its single result in the cycle after acceptance and never sets busy.
// Every level is one memory read (two read ports, one write port) plus a compare.
// Reset clears the count and control; the memory holds no reset value and needs no sweep.
// The receiver cannot stall: results go out one per cycle on done.
module top_k_smallest_heap
    import tksh_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
)
(
    input  wire  logic                clk,
    input  wire  logic                rst_n,
    input  wire  logic                start,
    output       logic                busy,
    input  wire  logic                req_type,
    input  wire  logic signed [DATA_W-1:0] value,
    input  wire  logic                k_limit_we,
    input  wire  logic [KLIMIT_W-1:0] k_limit,
    output       logic                done,
    output       logic signed [DATA_W-1:0] value_res,
    output       logic                last,
    output       logic                empty_res
);

    localparam int AW = $clog2(HEAP_DEPTH);          // heap address
    localparam int CW = $clog2(HEAP_DEPTH + 1);      // count 0..HEAP_DEPTH
    localparam int LW = AW + 2;                      // child index, up to 2*depth
    localparam int XW = ((CW > KLIMIT_W) ? CW : KLIMIT_W) + 1;

    localparam logic [KLIMIT_W-1:0] KLIM_MAX = KLIMIT_W'(HEAP_DEPTH - 1);
    localparam logic [KLIMIT_W-1:0] KLIM_RST =
        (KLIMIT_RESET > HEAP_DEPTH - 1) ? KLIM_MAX : KLIMIT_W'(KLIMIT_RESET);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,      // sift the new sample up, one level a cycle
        ST_RM_RD,   // read root and last entry
        ST_RM_LD,   // detach root, start sifting last entry down
        ST_DN,      // sift down, one level a cycle
        ST_EMIT     // stream sorted entries out
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [KLIMIT_W-1:0] klim_reg, klim_next;
    logic               drain_reg, drain_next;
    logic [AW-1:0]      hole_reg, hole_next;
    data_t              carry_reg, carry_next;
    logic [CW-1:0]      ntot_reg, ntot_next;
    logic [CW-1:0]      ecnt_reg, ecnt_next;
    logic               epend_reg, epend_next;
    logic               done_reg, done_next;
    data_t              value_res_reg, value_res_next;
    logic               last_reg, last_next;
    logic               empty_reg, empty_next;

    // Heap memory: one write port, two registered read ports
    data_t              heap_mem [HEAP_DEPTH];
    data_t              rd0_reg, rd1_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_wa, mem_ra0, mem_ra1;
    data_t              mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_wa] <= mem_wd;
        end
        rd0_reg <= heap_mem[mem_ra0];
        rd1_reg <= heap_mem[mem_ra1];
    end

    logic [AW-1:0] parent_idx, gparent_idx;
    logic [LW-1:0] lidx, ridx, n_ext, child_idx, gl_idx;
    logic [AW-1:0] child_aw;
    logic          l_in, r_in, pick_r;
    data_t         child_val;
    logic [CW-1:0] count_inc, count_dec;
    logic          over_limit;
    logic          emit_issue;

    always_comb
    begin
        parent_idx  = (hole_reg - AW'(1)) >> 1;
        gparent_idx = (parent_idx - AW'(1)) >> 1;
        lidx        = LW'({hole_reg, 1'b1});
        ridx        = lidx + LW'(1);
        n_ext       = LW'(count_reg);
        l_in        = lidx < n_ext;
        r_in        = ridx < n_ext;
        pick_r      = r_in && val_less(rd0_reg, rd1_reg);
        child_val   = pick_r ? rd1_reg : rd0_reg;
        child_idx   = pick_r ? ridx : lidx;
        child_aw    = child_idx[AW-1:0];
        gl_idx      = LW'({child_aw, 1'b1});
        count_inc   = count_reg + CW'(1);
        count_dec   = count_reg - CW'(1);
        over_limit  = XW'(count_inc) > XW'(klim_reg);
        emit_issue  = ecnt_reg < ntot_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        klim_next      = klim_reg;
        drain_next     = drain_reg;
        hole_next      = hole_reg;
        carry_next     = carry_reg;
        ntot_next      = ntot_reg;
        ecnt_next      = ecnt_reg;
        epend_next     = 1'b0;
        done_next      = 1'b0;
        value_res_next = value_res_reg;
        last_next      = 1'b0;
        empty_next     = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = hole_reg;
        mem_wd         = carry_reg;
        mem_ra0        = '0;
        mem_ra1        = '0;

        if (k_limit_we)
        begin
            klim_next = (k_limit > KLIM_MAX) ? KLIM_MAX : k_limit;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_PUSH)
                    begin
                        // Open a hole at the end and fetch its parent
                        hole_next  = count_reg[AW-1:0];
                        carry_next = value;
                        drain_next = 1'b0;
                        mem_ra0    = (count_reg[AW-1:0] - AW'(1)) >> 1;
                        state_next = ST_UP;
                    end
                    else if (count_reg == '0)
                    begin
                        done_next      = 1'b1;
                        last_next      = 1'b1;
                        empty_next     = 1'b1;
                        value_res_next = '0;
                    end
                    else
                    begin
                        drain_next = 1'b1;
                        ntot_next  = count_reg;
                        state_next = ST_RM_RD;
                    end
                end
            end
            ST_UP:
            begin
                mem_we = 1'b1;
                if (hole_reg == '0 || !val_less(rd0_reg, carry_reg))
                begin
                    count_next = count_inc;
                    state_next = over_limit ? ST_RM_RD : ST_IDLE;
                end
                else
                begin
                    // Move parent down into the hole, climb one level
                    mem_wd    = rd0_reg;
                    hole_next = parent_idx;
                    mem_ra0   = gparent_idx;
                end
            end
            ST_RM_RD:
            begin
                mem_ra0    = AW'(count_dec);
                mem_ra1    = '0;
                state_next = ST_RM_LD;
            end
            ST_RM_LD:
            begin
                carry_next = rd0_reg;
                count_next = count_dec;
                hole_next  = '0;
                if (drain_reg)
                begin
                    // Park the maximum in the freed slot: the array ends up ascending
                    mem_we = 1'b1;
                    mem_wa = AW'(count_dec);
                    mem_wd = rd1_reg;
                end
                mem_ra0    = AW'(1);
                mem_ra1    = AW'(2);
                state_next = ST_DN;
            end
            ST_DN:
            begin
                mem_we = 1'b1;
                if (!l_in || !val_less(carry_reg, child_val))
                begin
                    if (!drain_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        ecnt_next  = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_RM_RD;
                    end
                end
                else
                begin
                    // Pull the larger child up, descend one level
                    mem_wd    = child_val;
                    hole_next = child_aw;
                    mem_ra0   = gl_idx[AW-1:0];
                    mem_ra1   = AW'(gl_idx + LW'(1));
                end
            end
            ST_EMIT:
            begin
                if (emit_issue)
                begin
                    mem_ra0   = ecnt_reg[AW-1:0];
                    ecnt_next = ecnt_reg + CW'(1);
                end
                epend_next = emit_issue;
                if (epend_reg)
                begin
                    done_next      = 1'b1;
                    value_res_next = rd0_reg;
                    last_next      = (ecnt_reg == ntot_reg);
                    if (ecnt_reg == ntot_reg)
                    begin
                        drain_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            klim_reg      <= KLIM_RST;
            drain_reg     <= 1'b0;
            hole_reg      <= '0;
            carry_reg     <= '0;
            ntot_reg      <= '0;
            ecnt_reg      <= '0;
            epend_reg     <= 1'b0;
            done_reg      <= 1'b0;
            value_res_reg <= '0;
            last_reg      <= 1'b0;
            empty_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            klim_reg      <= klim_next;
            drain_reg     <= drain_next;
            hole_reg      <= hole_next;
            carry_reg     <= carry_next;
            ntot_reg      <= ntot_next;
            ecnt_reg      <= ecnt_next;
            epend_reg     <= epend_next;
            done_reg      <= done_next;
            value_res_reg <= value_res_next;
            last_reg      <= last_next;
            empty_reg     <= empty_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign value_res = value_res_reg;
    assign last      = last_reg;
    assign empty_res = empty_reg;

    // An empty drain reports a zero value and closes the drain
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        done && empty_res |-> last && value_res == '0)
        else $error("empty result without last or with nonzero value");

    // Drained items come out in ascending order, back to back
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |=> done && !val_less(value_res, $past(value_res)))
        else $error("drain output not ascending or not contiguous");

    // The heap is empty once the last item of a drain is out
    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && last |-> count_reg == '0)
        else $error("count not zero after drain");

    // The heap never holds more than depth minus one entries between items
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> count_reg <= CW'(HEAP_DEPTH - 1))
        else $error("kept count above heap bound");

    // A push always occupies the sequencer
    a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == REQ_PUSH |=> busy)
        else $error("push accepted without entering sift-up");

endmodule

`default_nettype wire

>>> tb/sv/top_k_checker.sv
// Checker for top_k_smallest_heap: mirrors the bounded max-heap and k_limit,
// predicts each drain's ordered results and compares them as they leave.
// Depends on tksh_pkg for the sample type, request codes and default depth.
module top_k_checker
    import tksh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                req_type,
    input  data_t               value,
    input  logic                k_limit_we,
    input  logic [KLIMIT_W-1:0] k_limit,
    input  logic                done,
    input  data_t               value_res,
    input  logic                last,
    input  logic                empty_res,
    output int                  fail_count,
    output int                  pending_results
);

    localparam int DEPTH = HEAP_DEPTH_DEF;

    typedef struct {
        data_t sample;
        logic  is_last;
        logic  is_empty;
    } kept_result_t;

    data_t        heap_mem [DEPTH];
    int unsigned  held;
    int unsigned  keep_max;
    kept_result_t drain_q [$];

    task automatic report_mismatch(input string msg);
        if (fail_count < 40)
            $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic void swap_entries(input int unsigned a, input int unsigned b);
        data_t t;
        t           = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endfunction

    // Ties never swap on the way up.
    function automatic void sift_up(input int unsigned idx);
        int unsigned i;
        int unsigned p;
        i = idx;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (heap_mem[p] < heap_mem[i])
            begin
                swap_entries(p, i);
                i = p;
            end
            else
                break;
        end
    endfunction

    // Prefer the left child on ties; swap only on strictly greater.
    function automatic void sift_down(input int unsigned n);
        int unsigned i;
        int unsigned l;
        int unsigned c;
        i = 0;
        forever
        begin
            l = 2 * i + 1;
            if (l >= n)
                break;
            c = l;
            if (l + 1 < n && heap_mem[l] < heap_mem[l + 1])
                c = l + 1;
            if (heap_mem[i] < heap_mem[c])
            begin
                swap_entries(i, c);
                i = c;
            end
            else
                break;
        end
    endfunction

    function automatic void drop_largest();
        if (held == 0)
            return;
        held--;
        heap_mem[0] = heap_mem[held];
        sift_down(held);
    endfunction

    function automatic void offer_sample(input data_t v);
        if (held < DEPTH)
        begin
            heap_mem[held] = v;
            sift_up(held);
            held++;
        end
        if (held > keep_max)
            drop_largest();
    endfunction

    // Extract maxima from the back so the queue ends up ascending.
    function automatic void predict_drain();
        kept_result_t outs [DEPTH];
        int           n;
        if (held == 0)
        begin
            drain_q.push_back('{sample: '0, is_last: 1'b1, is_empty: 1'b1});
            return;
        end
        n = held;
        for (int r = n - 1; r >= 0; r--)
        begin
            outs[r] = '{sample: heap_mem[0], is_last: (r == n - 1), is_empty: 1'b0};
            drop_largest();
        end
        for (int r = 0; r < n; r++)
            drain_q.push_back(outs[r]);
        held = 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kept_result_t want;
        if (!rst_n)
        begin
            held            = 0;
            keep_max        = (KLIMIT_RESET > DEPTH - 1) ? DEPTH - 1 : KLIMIT_RESET;
            fail_count      = 0;
            pending_results = 0;
            drain_q.delete();
        end
        else
        begin
            if (k_limit_we)
                keep_max = (k_limit > DEPTH - 1) ? DEPTH - 1 : k_limit;
            if (done)
            begin
                if (drain_q.size() == 0)
                    report_mismatch($sformatf("result %0d with nothing expected", value_res));
                else
                begin
                    want = drain_q.pop_front();
                    if (value_res !== want.sample)
                        report_mismatch($sformatf("value_res %0d, expected %0d",
                                                  value_res, want.sample));
                    if (last !== want.is_last)
                        report_mismatch($sformatf("last %b, expected %b", last, want.is_last));
                    if (empty_res !== want.is_empty)
                        report_mismatch($sformatf("empty_res %b, expected %b",
                                                  empty_res, want.is_empty));
                end
            end
            if (start && !busy)
            begin
                if (req_type == REQ_PUSH)
                    offer_sample(value);
                else
                    predict_drain();
            end
            pending_results = drain_q.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the top_k_smallest_heap testbench: clock, reset, stimulus, watchdog, verdict.
// Depends on tksh_pkg, top_k_smallest_heap and top_k_checker.
module testbench
    import tksh_pkg::*;
();

    localparam int    SETTLE_CYCLES = 40;    // time for a trailing push to finish
    localparam int    IDLE_LIMIT    = 4000;  // a full drain is silent until its removals are done
    localparam int    DIRECTED_ITEMS = 92;
    localparam int    RANDOM_ITEMS  = 30;
    localparam data_t SAMPLE_MIN    = {1'b1, {(DATA_W-1){1'b0}}};
    localparam data_t SAMPLE_MAX    = {1'b0, {(DATA_W-1){1'b1}}};

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                req_type;
    data_t               value;
    logic                k_limit_we;
    logic [KLIMIT_W-1:0] k_limit;
    logic                busy;
    logic                done;
    data_t               value_res;
    logic                last;
    logic                empty_res;

    int fail_count;
    int pending_results;
    int items_sent;
    int drains_sent;
    int results_seen;
    int quiet_cycles;
    bit no_gaps;

    top_k_smallest_heap i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .value      (value),
        .k_limit_we (k_limit_we),
        .k_limit    (k_limit),
        .done       (done),
        .value_res  (value_res),
        .last       (last),
        .empty_res  (empty_res)
    );

    top_k_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .value           (value),
        .k_limit_we      (k_limit_we),
        .k_limit         (k_limit),
        .done            (done),
        .value_res       (value_res),
        .last            (last),
        .empty_res       (empty_res),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always #2 clk = ~clk;

    // Count results, and end the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                results_seen++;
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Mix extremes, a narrow band around zero (to force ties) and full-width noise.
    function automatic data_t rand_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2, 3:    return data_t'($urandom_range(0, 15)) - 8;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Present one item at the falling edge and hold it until the block takes it.
    // Start stays high when the next item follows without a gap.
    task automatic send_item(input logic kind, input data_t sample);
        @(negedge clk);
        start    <= 1'b1;
        req_type <= kind;
        value    <= sample;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (kind == REQ_DRAIN)
            drains_sent++;
        if (!no_gaps && $urandom_range(0, 99) < 35)
            repeat ($urandom_range(1, 4))
                @(negedge clk) start <= 1'b0;
    endtask

    // Drop start, wait for every expected result, give a trailing push time to
    // finish, then wait out busy.
    task automatic wait_quiet();
        @(negedge clk) start <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic write_limit(input logic [KLIMIT_W-1:0] kv);
        wait_quiet();
        @(negedge clk);
        k_limit_we <= 1'b1;
        k_limit    <= kv;
        @(negedge clk) k_limit_we <= 1'b0;
    endtask

    // Mostly pushes, with the odd drain thrown in as noise.
    task automatic push_burst(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(REQ_DRAIN, rand_sample());
            else
                send_item(REQ_PUSH, rand_sample());
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        req_type   = REQ_PUSH;
        value      = '0;
        k_limit_we = 1'b0;
        k_limit    = '0;
        no_gaps    = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed: empty drain at the reset limit, extremes and ties.
        send_item(REQ_DRAIN, SAMPLE_MAX);
        send_item(REQ_PUSH, SAMPLE_MAX);
        send_item(REQ_PUSH, SAMPLE_MIN);
        send_item(REQ_PUSH, 0);
        send_item(REQ_PUSH, -1);
        send_item(REQ_PUSH, 1);
        send_item(REQ_PUSH, 5);
        send_item(REQ_PUSH, 5);
        send_item(REQ_PUSH, SAMPLE_MIN);
        send_item(REQ_DRAIN, 0);

        // Zero limit: every push is trimmed at once, the drain comes back empty.
        write_limit(0);
        send_item(REQ_PUSH, 3);
        send_item(REQ_PUSH, SAMPLE_MIN);
        send_item(REQ_DRAIN, 0);

        // Keep two with equal values competing for the slots.
        write_limit(2);
        send_item(REQ_PUSH, 9);
        send_item(REQ_PUSH, 9);
        send_item(REQ_PUSH, 1);
        send_item(REQ_PUSH, 9);
        send_item(REQ_DRAIN, 0);

        // Lower the limit under a fuller heap: each push trims only one maximum.
        write_limit(63);
        send_item(REQ_PUSH, 4);
        send_item(REQ_PUSH, 3);
        send_item(REQ_PUSH, 2);
        send_item(REQ_PUSH, 1);
        write_limit(1);
        send_item(REQ_PUSH, 7);
        send_item(REQ_PUSH, 0);
        send_item(REQ_DRAIN, 0);

        // Fill the heap past its depth back to back, then drain it whole.
        write_limit(63);
        no_gaps = 1'b1;
        repeat (66)
            send_item(REQ_PUSH, rand_sample());
        send_item(REQ_DRAIN, 0);
        no_gaps = 1'b0;

        // Random phases: new limit, a few bursts, most ending in a drain; a
        // skipped drain lets the next limit land on a loaded heap.
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       write_limit(0);
                1:       write_limit(1);
                2:       write_limit(63);
                default: write_limit(KLIMIT_W'($urandom_range(1, 63)));
            endcase
            repeat ($urandom_range(1, 3))
            begin
                push_burst($urandom_range(0, 12));
                if ($urandom_range(0, 3) != 0)
                    send_item(REQ_DRAIN, rand_sample());
                if ($urandom_range(0, 3) == 0)
                    wait_quiet();
            end
        end

        send_item(REQ_DRAIN, 0);
        wait_quiet();

        $display("sent %0d items (%0d drains), checked %0d results", items_sent,
                 drains_sent, results_seen);
        $display("covered limits 0, 1, 2, 63 and random, ties, extremes, overfull heap");
        if (fail_count == 0 && pending_results == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
design/tksh_pkg.sv
design/top_k_smallest_heap.sv
tb/sv/top_k_checker.sv
tb/sv/testbench.sv
